FILE: rtl/rfe_pkg.sv
// ----------------------------------------------------------------------------
// rfe_pkg
// Shared types and codes for the rectangle fill engine.
// ----------------------------------------------------------------------------
package rfe_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		SEL_CONTROL = 3'd0,
		SEL_STATUS  = 3'd1,
		SEL_CLEAR   = 3'd2,
		SEL_COLOUR  = 3'd3,
		SEL_ADDRESS = 3'd4,
		SEL_OFFSET  = 3'd5,
		SEL_LINE    = 3'd6
	} sel_t;

	localparam int unsigned USER_IN_W = 5;
	localparam int unsigned DATA_IN_W = 32;
	localparam int unsigned DATA_OUT_W = 88;
	localparam int unsigned LINE_LSB = 16;

	typedef struct packed {
		cmd_t        command;
		sel_t        reg_select;
		logic [31:0] write_data;
	} item_t;

	typedef struct packed {
		logic        busy_res;
		logic [15:0] mem_data;
		logic [31:0] mem_address;
		logic        mem_write;
		logic [31:0] read_data;
	} result_t;

endpackage

FILE: rtl/rectangle_fill_engine_top.sv
// ----------------------------------------------------------------------------
// rectangle_fill_engine_top
// Rectangle fill engine: stream of bus commands in, one result word out each.
//
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser: command, reg_select; s_tdata: write_data
// m_       out  m_tvalid/m_tready  m_tdata: read_data .. busy_res
//
// One word in per cycle while the result is not stalled, one word out per word in; each
// word passes an input register, then a result register. The register file and fill walker
// update in the cycle a word leaves the input register.
// Reset clears the engine registers and both valid flags; the block is ready at once.
// A stalled result holds; the input register still fills behind it.
// ----------------------------------------------------------------------------
module rectangle_fill_engine_top #(
	parameter int unsigned PIXEL_COUNT_BITS = 14
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [rfe_pkg::DATA_IN_W-1:0]       s_tdata,  // write_data[31:0]
	input  logic [rfe_pkg::USER_IN_W-1:0]       s_tuser,  // command[1:0], reg_select[4:2]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [rfe_pkg::DATA_OUT_W-1:0]      m_tdata   // read_data[31:0], mem_write[32],
	                                                      // mem_address[64:33],
	                                                      // mem_data[80:65], busy_res[81]
);

	logic             valid_s1;
	rfe_pkg::item_t   item_s1;
	logic             advance;
	rfe_pkg::result_t result;
	rfe_pkg::result_t result_s2;
	logic             valid_s2;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command    <= rfe_pkg::cmd_t'(s_tuser[1:0]);
			item_s1.reg_select <= rfe_pkg::sel_t'(s_tuser[4:2]);
			item_s1.write_data <= s_tdata;
		end
	end

	rfe_engine #(
		.PIXEL_COUNT_BITS(PIXEL_COUNT_BITS)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_s2 <= result;
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, result_s2};

endmodule

FILE: rtl/rfe_engine.sv
// ----------------------------------------------------------------------------
// rfe_engine
// Register file, fill walker and one-word result logic of the fill engine.
// ----------------------------------------------------------------------------
module rfe_engine #(
	parameter int unsigned PIXEL_COUNT_BITS = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  rfe_pkg::item_t   item,
	output rfe_pkg::result_t result
);

	logic [15:0]                 colour_q, colour_d;
	logic [31:0]                 base_q, base_d;
	logic [15:0]                 offset_q, offset_d;
	logic [PIXEL_COUNT_BITS-1:0] ppl_q, ppl_d;
	logic [15:0]                 lines_q, lines_d;
	logic                        running_q, running_d;
	logic                        done_q, done_d;
	logic [31:0]                 addr_q, addr_d;
	logic [PIXEL_COUNT_BITS-1:0] col_q, col_d;
	logic [15:0]                 row_q, row_d;

	logic [PIXEL_COUNT_BITS-1:0] col_inc;
	logic [15:0]                 row_inc;
	logic [31:0]                 line_step;

	assign col_inc   = col_q + 1'b1;
	assign row_inc   = row_q + 1'b1;
	assign line_step = 32'd2 + {15'd0, offset_q, 1'b0};

	always_comb begin
		colour_d  = colour_q;
		base_d    = base_q;
		offset_d  = offset_q;
		ppl_d     = ppl_q;
		lines_d   = lines_q;
		running_d = running_q;
		done_d    = done_q;
		addr_d    = addr_q;
		col_d     = col_q;
		row_d     = row_q;
		result    = '0;
		unique case (item.command)
			rfe_pkg::CMD_WRITE: begin
				if (item.reg_select == rfe_pkg::SEL_CLEAR) begin
					if (item.write_data[0])
						done_d = 1'b0;
				end else if (!running_q) begin
					unique case (item.reg_select)
						rfe_pkg::SEL_CONTROL: begin
							if (item.write_data[0]) begin
								if (ppl_q == '0 || lines_q == '0) begin
									done_d = 1'b1;
								end else begin
									running_d = 1'b1;
									addr_d    = base_q;
									col_d     = '0;
									row_d     = '0;
								end
							end
						end
						rfe_pkg::SEL_COLOUR:  colour_d = item.write_data[15:0];
						rfe_pkg::SEL_ADDRESS: base_d   = item.write_data;
						rfe_pkg::SEL_OFFSET:  offset_d = item.write_data[15:0];
						rfe_pkg::SEL_LINE: begin
							ppl_d   = item.write_data[rfe_pkg::LINE_LSB +: PIXEL_COUNT_BITS];
							lines_d = item.write_data[15:0];
						end
						default: ;
					endcase
				end
			end
			rfe_pkg::CMD_READ: begin
				unique case (item.reg_select)
					rfe_pkg::SEL_CONTROL: result.read_data = {31'd0, running_q};
					rfe_pkg::SEL_STATUS:  result.read_data = {31'd0, done_q};
					rfe_pkg::SEL_COLOUR:  result.read_data = {16'd0, colour_q};
					rfe_pkg::SEL_ADDRESS: result.read_data = base_q;
					rfe_pkg::SEL_OFFSET:  result.read_data = {16'd0, offset_q};
					rfe_pkg::SEL_LINE: begin
						result.read_data = {(16)'(ppl_q), lines_q};
					end
					default: result.read_data = '0;
				endcase
			end
			rfe_pkg::CMD_TICK: begin
				if (running_q) begin
					result.mem_write   = 1'b1;
					result.mem_address = addr_q;
					result.mem_data    = colour_q;
					if (col_inc == ppl_q) begin
						col_d  = '0;
						row_d  = row_inc;
						addr_d = addr_q + line_step;
						if (row_inc == lines_q) begin
							running_d = 1'b0;
							done_d    = 1'b1;
						end
					end else begin
						col_d  = col_inc;
						addr_d = addr_q + 32'd2;
					end
				end
			end
			default: ;
		endcase
		result.busy_res = running_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_q  <= '0;
			base_q    <= '0;
			offset_q  <= '0;
			ppl_q     <= '0;
			lines_q   <= '0;
			running_q <= 1'b0;
			done_q    <= 1'b0;
			addr_q    <= '0;
			col_q     <= '0;
			row_q     <= '0;
		end else if (step) begin
			colour_q  <= colour_d;
			base_q    <= base_d;
			offset_q  <= offset_d;
			ppl_q     <= ppl_d;
			lines_q   <= lines_d;
			running_q <= running_d;
			done_q    <= done_d;
			addr_q    <= addr_d;
			col_q     <= col_d;
			row_q     <= row_d;
		end
	end

endmodule

FILE: rtl/rfe_checker.sv
// ----------------------------------------------------------------------------
// rfe_checker
// Port-level checks for the rectangle fill engine.
// ----------------------------------------------------------------------------
module rfe_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic                           m_tvalid,
	input logic                           m_tready,
	input logic [rfe_pkg::DATA_OUT_W-1:0] m_tdata
);

	logic last_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_busy_q <= 1'b0;
		end else if (m_tvalid && m_tready) begin
			last_busy_q <= m_tdata[81];
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	a_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("result word without a matching input word");

	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[32] ? (m_tdata[31:0] == 32'd0)
			: (m_tdata[64:33] == 32'd0 && m_tdata[80:65] == 16'd0)))
		else $error("memory and read fields overlap");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tdata[32] |-> last_busy_q)
		else $error("pixel write while engine idle");

	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[87:82] == 6'd0)
		else $error("padding bits set");

endmodule

bind rectangle_fill_engine_top rfe_checker u_rfe_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for rectangle_fill_engine_top. A short table of directed command
// words (reset values, register extremes, ignored writes, zero-sized start,
// restart with done set) is followed by random fill programs with random
// geometry, interleaved reads, writes while busy and noise. Every accepted
// word is run through a local model of the engine, and each result word is
// compared field by field with the oldest prediction. Both stream sides
// idle in random bursts, except in a quiet stretch at the end.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIXEL_BITS = 14;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam logic [2:0] SEL_UNUSED = 3'd7;
	localparam int ITEM_GOAL = 800;
	localparam int QUIET_TAIL = 700;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		logic [1:0]  c;
		logic [2:0]  s;
		logic [31:0] d;
		logic        fixed;
		logic [31:0] rd;
		logic        busy;
	} plan_row_t;

	plan_row_t plan[] = '{
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_CONTROL, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_STATUS, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_LINE, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, SEL_UNUSED, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_TICK, rfe_pkg::SEL_CONTROL, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CONTROL, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_STATUS, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CLEAR, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CLEAR, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_CLEAR, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_COLOUR, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_COLOUR, 32'h0000_0000, 1'b1, 32'h0000_FFFF, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_ADDRESS, 32'hFFFF_FFFC, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_ADDRESS, 32'h0000_0000, 1'b1, 32'hFFFF_FFFC, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_OFFSET, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_OFFSET, 32'h0000_0000, 1'b1, 32'h0000_FFFF, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_LINE, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_LINE, 32'h0000_0000, 1'b1, 32'h3FFF_FFFF, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_LINE, 32'h0002_0002, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_STATUS, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{CMD_UNUSED, SEL_UNUSED, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_WRITE, SEL_UNUSED, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CONTROL, 32'hFFFF_FFFE, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_CONTROL, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CONTROL, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_CONTROL, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b1},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_COLOUR, 32'h0000_1234, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_TICK, rfe_pkg::SEL_CONTROL, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_TICK, rfe_pkg::SEL_STATUS, 32'hFFFF_FFFF, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_TICK, SEL_UNUSED, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_TICK, rfe_pkg::SEL_LINE, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_STATUS, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_COLOUR, 32'h0000_0000, 1'b1, 32'h0000_FFFF, 1'b0},
		'{rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CONTROL, 32'h0000_0001, 1'b0, 32'h0000_0000, 1'b0},
		'{rfe_pkg::CMD_READ, rfe_pkg::SEL_STATUS, 32'h0000_0000, 1'b1, 32'h0000_0001, 1'b1}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [rfe_pkg::DATA_IN_W-1:0] s_tdata = '0;
	logic [rfe_pkg::USER_IN_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [rfe_pkg::DATA_OUT_W-1:0] m_tdata;

	// engine model state
	logic [15:0]           pen_colour;
	logic [31:0]           origin_addr;
	logic [15:0]           stride_px;
	logic [PIXEL_BITS-1:0] row_pixels;
	logic [15:0]           row_total;
	logic                  fill_busy;
	logic                  fill_done;
	logic [31:0]           write_ptr;
	logic [PIXEL_BITS-1:0] col_pos;
	logic [15:0]           row_pos;

	rfe_pkg::result_t awaited_results[$];
	rfe_pkg::result_t seen_res;
	rfe_pkg::result_t due_res;
	bit      bursts_on = 1'b1;
	int      stall_left = 0;
	int      quiet_cycles = 0;
	int      error_count = 0;
	int      words_sent = 0;
	int      results_seen = 0;
	int      pixels_seen = 0;
	int      fills_started = 0;

	rectangle_fill_engine_top #(
		.PIXEL_COUNT_BITS(PIXEL_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic log_error(input string what, input rfe_pkg::result_t want,
		input rfe_pkg::result_t got);
		if (error_count < 10) begin
			$display("%0t %s: want rd=%h wr=%b addr=%h pix=%h busy=%b", $realtime, what,
				want.read_data, want.mem_write, want.mem_address, want.mem_data, want.busy_res);
			$display("           got  rd=%h wr=%b addr=%h pix=%h busy=%b",
				got.read_data, got.mem_write, got.mem_address, got.mem_data, got.busy_res);
		end
		error_count++;
	endtask

	task automatic fill_predict(input logic [1:0] c, input logic [2:0] s,
		input logic [31:0] d, output rfe_pkg::result_t r);
		r = '0;
		case (c)
			rfe_pkg::CMD_WRITE: begin
				if (s == rfe_pkg::SEL_CLEAR) begin
					if (d[0])
						fill_done = 1'b0;
				end else if (!fill_busy) begin
					case (s)
						rfe_pkg::SEL_CONTROL: begin
							if (d[0]) begin
								if (row_pixels == '0 || row_total == '0) begin
									fill_done = 1'b1;
								end else begin
									fill_busy = 1'b1;
									write_ptr = origin_addr;
									col_pos = '0;
									row_pos = '0;
									fills_started++;
								end
							end
						end
						rfe_pkg::SEL_COLOUR:  pen_colour = d[15:0];
						rfe_pkg::SEL_ADDRESS: origin_addr = d;
						rfe_pkg::SEL_OFFSET:  stride_px = d[15:0];
						rfe_pkg::SEL_LINE: begin
							row_pixels = d[rfe_pkg::LINE_LSB +: PIXEL_BITS];
							row_total = d[15:0];
						end
						default: ;
					endcase
				end
			end
			rfe_pkg::CMD_READ: begin
				case (s)
					rfe_pkg::SEL_CONTROL: r.read_data = {31'd0, fill_busy};
					rfe_pkg::SEL_STATUS:  r.read_data = {31'd0, fill_done};
					rfe_pkg::SEL_COLOUR:  r.read_data = {16'd0, pen_colour};
					rfe_pkg::SEL_ADDRESS: r.read_data = origin_addr;
					rfe_pkg::SEL_OFFSET:  r.read_data = {16'd0, stride_px};
					rfe_pkg::SEL_LINE:
						r.read_data = (32'(row_pixels) << rfe_pkg::LINE_LSB) | 32'(row_total);
					default:     r.read_data = '0;
				endcase
			end
			rfe_pkg::CMD_TICK: begin
				if (fill_busy) begin
					r.mem_write = 1'b1;
					r.mem_address = write_ptr;
					r.mem_data = pen_colour;
					col_pos = col_pos + 1'b1;
					if (col_pos == row_pixels) begin
						col_pos = '0;
						row_pos = row_pos + 1'b1;
						write_ptr = write_ptr + 32'd2 + {15'd0, stride_px, 1'b0};
						if (row_pos == row_total) begin
							fill_busy = 1'b0;
							fill_done = 1'b1;
						end
					end else begin
						write_ptr = write_ptr + 32'd2;
					end
				end
			end
			default: ;
		endcase
		r.busy_res = fill_busy;
	endtask

	task automatic send_word(input logic [1:0] c, input logic [2:0] s, input logic [31:0] d);
		rfe_pkg::result_t r;
		if (bursts_on && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= {s, c};
		s_tdata <= d;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		fill_predict(c, s, d, r);
		awaited_results.push_back(r);
		words_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
	endtask

	// result side: check, then pick ready for the next edge
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_res = rfe_pkg::result_t'(m_tdata[$bits(rfe_pkg::result_t)-1:0]);
			results_seen++;
			if (seen_res.mem_write)
				pixels_seen++;
			if (awaited_results.size() == 0) begin
				log_error("unexpected result word", '0, seen_res);
			end else begin
				due_res = awaited_results.pop_front();
				if (seen_res.read_data !== due_res.read_data ||
					seen_res.mem_write !== due_res.mem_write ||
					seen_res.mem_address !== due_res.mem_address ||
					seen_res.mem_data !== due_res.mem_data ||
					seen_res.busy_res !== due_res.busy_res)
					log_error("result mismatch", due_res, seen_res);
			end
		end
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (bursts_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int seq_no;
		int pick;
		logic [1:0] nc;
		logic [2:0] ns;
		logic [31:0] nd;
		logic [PIXEL_BITS-1:0] ppl;
		logic [15:0] lines;

		pen_colour = '0;
		origin_addr = '0;
		stride_px = '0;
		row_pixels = '0;
		row_total = '0;
		fill_busy = 1'b0;
		fill_done = 1'b0;
		write_ptr = '0;
		col_pos = '0;
		row_pos = '0;
		seq_no = 0;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			send_word(plan[i].c, plan[i].s, plan[i].d);
			if (plan[i].fixed) begin
				// swap the model's value for the one typed in the table
				void'(awaited_results.pop_back());
				due_res = '0;
				due_res.read_data = plan[i].rd;
				due_res.busy_res = plan[i].busy;
				awaited_results.push_back(due_res);
			end
		end
		wait_drained();

		while (words_sent < ITEM_GOAL) begin
			seq_no++;
			bursts_on = (words_sent < QUIET_TAIL) && ($urandom_range(0, 3) != 0);

			repeat ($urandom_range(0, 3)) begin
				nc = 2'($urandom_range(0, 3));
				ns = 3'($urandom_range(0, 7));
				nd = $urandom;
				// keep noise geometry small
				if (nc == rfe_pkg::CMD_WRITE && ns == rfe_pkg::SEL_LINE)
					nd = nd & 32'hC007_0007;
				send_word(nc, ns, nd);
			end

			if ($urandom_range(0, 7) != 0)
				send_word(rfe_pkg::CMD_WRITE, rfe_pkg::SEL_COLOUR, $urandom);
			if ($urandom_range(0, 7) != 0)
				send_word(rfe_pkg::CMD_WRITE, rfe_pkg::SEL_ADDRESS,
					($urandom_range(0, 5) == 0) ?
					(32'hFFFF_FFE0 | $urandom_range(0, 31)) : $urandom);
			if ($urandom_range(0, 7) != 0)
				send_word(rfe_pkg::CMD_WRITE, rfe_pkg::SEL_OFFSET,
					($urandom_range(0, 7) == 0) ? $urandom :
					(($urandom & 32'hFFFF_0000) | $urandom_range(0, 8)));

			pick = $urandom_range(0, 39);
			if (pick == 0) begin
				ppl = '0;
				lines = 16'($urandom_range(0, 4));
			end else if (pick == 1) begin
				ppl = PIXEL_BITS'($urandom_range(0, 6));
				lines = '0;
			end else if (pick < 4) begin
				ppl = PIXEL_BITS'($urandom_range(7, 64));
				lines = 16'($urandom_range(1, 2));
			end else if (pick < 6) begin
				ppl = PIXEL_BITS'($urandom_range(1, 6));
				lines = 16'($urandom_range(5, 20));
			end else begin
				ppl = PIXEL_BITS'($urandom_range(1, 6));
				lines = 16'($urandom_range(1, 4));
			end
			send_word(rfe_pkg::CMD_WRITE, rfe_pkg::SEL_LINE,
				($urandom & 32'hC000_0000) | (32'(ppl) << rfe_pkg::LINE_LSB) | 32'(lines));

			if ($urandom_range(0, 3) == 0)
				send_word(rfe_pkg::CMD_READ,
					3'($urandom_range(rfe_pkg::SEL_COLOUR, rfe_pkg::SEL_LINE)), $urandom);
			send_word(rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CONTROL, $urandom | 32'd1);

			while (fill_busy) begin
				pick = $urandom_range(0, 9);
				if (pick < 7)
					send_word(rfe_pkg::CMD_TICK, 3'($urandom_range(0, 7)), $urandom);
				else if (pick == 7)
					send_word(rfe_pkg::CMD_READ, 3'($urandom_range(0, 7)), $urandom);
				else if (pick == 8)
					send_word(rfe_pkg::CMD_WRITE, 3'($urandom_range(0, 7)), $urandom);
				else
					send_word(CMD_UNUSED, 3'($urandom_range(0, 7)), $urandom);
			end

			send_word(rfe_pkg::CMD_READ, rfe_pkg::SEL_STATUS, $urandom);
			if ($urandom_range(0, 2) != 0)
				send_word(rfe_pkg::CMD_WRITE, rfe_pkg::SEL_CLEAR, $urandom | 32'd1);
			if (seq_no % 8 == 0)
				wait_drained();
		end

		bursts_on = 1'b0;
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		while (awaited_results.size() != 0)
			log_error("result never arrived", awaited_results.pop_front(), '0);

		$display("Sent %0d command words over %0d fill programs; checked %0d result words.",
			words_sent, seq_no, results_seen);
		$display("%0d fills ran, %0d pixel writes compared against the model.",
			fills_started, pixels_seen);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
